[hdl/bzf_pkg.sv]
// ----------------------------------------------------------------------------
// bzf_pkg
// Shared types, widths and helpers of the quadratic Bezier flattener.
// ----------------------------------------------------------------------------
package bzf_pkg;

   // Coordinate format of every point on both channels
   localparam int COORD_W   = 16;
   // Default step count STEPS; each curve gives STEPS+1 segments
   localparam int STEPS_DEF = 50;

   typedef logic signed [COORD_W-1:0] coord_type;

   // Control word that travels down the pipeline with each segment
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } ctl_type;

   // Width of a Bernstein weight; the largest weight is STEPS squared
   function automatic int weight_width(input int steps);
      return $clog2(steps * steps + 1);
   endfunction

   // Width of the step counter, which must reach STEPS itself
   function automatic int step_width(input int steps);
      return (steps < 2) ? 1 : $clog2(steps + 1);
   endfunction

endpackage

[hdl/bzf_req_if.sv]
// ----------------------------------------------------------------------------
// bzf_req_if
// Curve channel: start, control and end point of one quadratic curve.
// ----------------------------------------------------------------------------
interface bzf_req_if;
   import bzf_pkg::*;

   logic      valid;
   logic      ready;
   coord_type start_x;
   coord_type start_y;
   coord_type ctrl_x;
   coord_type ctrl_y;
   coord_type finish_x;
   coord_type finish_y;

   modport source (
      output valid, start_x, start_y, ctrl_x, ctrl_y, finish_x, finish_y,
      input  ready
   );

   modport sink (
      input  valid, start_x, start_y, ctrl_x, ctrl_y, finish_x, finish_y,
      output ready
   );

endinterface

[hdl/bzf_rsp_if.sv]
// ----------------------------------------------------------------------------
// bzf_rsp_if
// Segment channel: current point, previous point and end-of-curve flag.
// ----------------------------------------------------------------------------
interface bzf_rsp_if;
   import bzf_pkg::*;

   logic      valid;
   logic      ready;
   coord_type cur_x;
   coord_type cur_y;
   coord_type prev_x;
   coord_type prev_y;
   logic      last;

   modport source (
      output valid, cur_x, cur_y, prev_x, prev_y, last,
      input  ready
   );

   modport sink (
      input  valid, cur_x, cur_y, prev_x, prev_y, last,
      output ready
   );

endinterface

[hdl/bzf_seq.sv]
// ----------------------------------------------------------------------------
// bzf_seq
// Step sequencer: holds the current curve, walks k from 0 to STEPS and
// registers the three Bernstein weights with the control points.
// ----------------------------------------------------------------------------
module bzf_seq #(
   parameter int STEPS = bzf_pkg::STEPS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   bzf_req_if.sink                                req_ch,
   output bzf_pkg::ctl_type                       s1_ctl,
   output logic [2:0][bzf_pkg::weight_width(STEPS)-1:0] s1_wgt,
   output bzf_pkg::coord_type [1:0][2:0]          s1_pts
);
   import bzf_pkg::*;

   localparam int WW  = weight_width(STEPS);
   localparam int K_W = step_width(STEPS);
   localparam logic [K_W-1:0] STEPS_K = K_W'(STEPS);

   logic                   busy_ff;
   logic [K_W-1:0]         k_ff;
   coord_type [1:0][2:0]   pts_ff;

   ctl_type                s1_ctl_ff;
   logic [2:0][WW-1:0]     s1_wgt_ff;
   coord_type [1:0][2:0]   s1_pts_ff;

   logic                   at_end;
   logic                   take;
   logic [K_W-1:0]         rem;
   logic [WW-1:0]          k_w;
   logic [WW-1:0]          rem_w;
   logic [2:0][WW-1:0]     wgt_in;

   // Accept a new curve while the pipeline advances, when idle or while the last step leaves
   assign at_end       = (k_ff == STEPS_K);
   assign req_ch.ready = advance && (!busy_ff || at_end);
   assign take         = req_ch.valid && req_ch.ready;

   // Bernstein weights of step k: (S-k)^2, 2k(S-k), k^2
   always_comb begin
      rem       = STEPS_K - k_ff;
      k_w       = WW'(k_ff);
      rem_w     = WW'(rem);
      wgt_in[0] = rem_w * rem_w;
      wgt_in[1] = (k_w * rem_w) << 1;
      wgt_in[2] = k_w * k_w;
   end

   // Hold the curve and step through it
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         k_ff    <= '0;
      end else if (advance) begin
         if (take) begin
            busy_ff <= 1'b1;
            k_ff    <= '0;
         end else if (busy_ff) begin
            if (at_end) begin
               busy_ff <= 1'b0;
               k_ff    <= '0;
            end else begin
               k_ff <= k_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pts_ff[0][0] <= req_ch.start_x;
         pts_ff[0][1] <= req_ch.ctrl_x;
         pts_ff[0][2] <= req_ch.finish_x;
         pts_ff[1][0] <= req_ch.start_y;
         pts_ff[1][1] <= req_ch.ctrl_y;
         pts_ff[1][2] <= req_ch.finish_y;
      end
   end

   // Issue one step per advancing cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
      end else if (advance) begin
         s1_ctl_ff.valid <= busy_ff;
         s1_ctl_ff.first <= busy_ff && (k_ff == '0);
         s1_ctl_ff.last  <= busy_ff && at_end;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_wgt_ff <= wgt_in;
         s1_pts_ff <= pts_ff;
      end
   end

   assign s1_ctl = s1_ctl_ff;
   assign s1_wgt = s1_wgt_ff;
   assign s1_pts = s1_pts_ff;

   // Step counter never runs past the final step
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (k_ff <= STEPS_K))
      else $error("step counter beyond final step");

   // A new curve enters a busy sequencer only as the old one finishes
   a_accept_end: assert property (@(posedge clock) disable iff (reset)
      (take && busy_ff) |-> at_end)
      else $error("curve accepted mid-walk");

   // Every advancing busy cycle issues a valid step
   a_issue: assert property (@(posedge clock) disable iff (reset)
      (advance && busy_ff) |=> s1_ctl_ff.valid)
      else $error("busy sequencer issued a bubble");

endmodule

[hdl/bzf_eval.sv]
// ----------------------------------------------------------------------------
// bzf_eval
// Point evaluator: weighted sum of the control points, then exact division
// by STEPS squared through a reciprocal multiply, truncated toward zero.
// ----------------------------------------------------------------------------
module bzf_eval #(
   parameter int STEPS = bzf_pkg::STEPS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   input  bzf_pkg::ctl_type                       s1_ctl,
   input  logic [2:0][bzf_pkg::weight_width(STEPS)-1:0] s1_wgt,
   input  bzf_pkg::coord_type [1:0][2:0]          s1_pts,
   output bzf_pkg::ctl_type                       ev_ctl,
   output bzf_pkg::coord_type [1:0]               ev_cur
);
   import bzf_pkg::*;

   localparam int WW     = weight_width(STEPS);
   localparam int DIV    = STEPS * STEPS;
   localparam int PROD_W = COORD_W + WW + 1;
   localparam int NUM_W  = PROD_W + 2;
   // Width of the largest magnitude of a weighted sum
   localparam int MAG_W  = $clog2(DIV * (2 ** (COORD_W - 1)) + 1);
   // Shift wide enough that the rounded-up reciprocal is exact below 2^MAG_W
   localparam int SH     = MAG_W + $clog2(DIV);
   localparam logic [63:0] ONE_SH = 64'd1 << SH;
   localparam logic [63:0] RECIP  = (ONE_SH + 64'(DIV) - 64'd1) / 64'(DIV);
   localparam int M_W    = $clog2(RECIP + 64'd1);
   localparam logic [M_W-1:0] RECIP_M = M_W'(RECIP);
   localparam int SC_W   = MAG_W + M_W;

   ctl_type                        e1_ctl_ff;
   logic signed [PROD_W-1:0]       prod_ff [2][3];
   logic signed [PROD_W-1:0]       prod_in [2][3];

   ctl_type                        e2_ctl_ff;
   logic [MAG_W-1:0]               mag_ff [2];
   logic [MAG_W-1:0]               mag_in [2];
   logic [1:0]                     neg_ff;
   logic [1:0]                     neg_in;
   logic signed [NUM_W-1:0]        num [2];
   logic [NUM_W-1:0]               abs_num [2];

   ctl_type                        e3_ctl_ff;
   logic [SC_W-1:0]                scaled_ff [2];
   logic [1:0]                     neg3_ff;

   logic [SC_W-1:0]                shifted [2];
   coord_type                      quot [2];

   // Stage 1: weight times coordinate, three terms per axis
   always_comb begin
      for (int a = 0; a < 2; a++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[a][j] = $signed(s1_pts[a][j]) * $signed({1'b0, s1_wgt[j]});
         end
      end
   end

   // Stage 2: sum the terms and split off the sign
   always_comb begin
      for (int a = 0; a < 2; a++) begin
         num[a]     = NUM_W'(prod_ff[a][0]) + NUM_W'(prod_ff[a][1])
                    + NUM_W'(prod_ff[a][2]);
         neg_in[a]  = num[a][NUM_W-1];
         abs_num[a] = neg_in[a] ? NUM_W'(-num[a]) : NUM_W'(num[a]);
         mag_in[a]  = abs_num[a][MAG_W-1:0];
      end
   end

   // Stage 4 logic: drop the fraction, restore the sign
   always_comb begin
      for (int a = 0; a < 2; a++) begin
         shifted[a] = scaled_ff[a] >> SH;
         quot[a]    = shifted[a][COORD_W-1:0];
         ev_cur[a]  = neg3_ff[a] ? -quot[a] : quot[a];
      end
   end

   // Advance the control words
   always_ff @(posedge clock) begin
      if (reset) begin
         e1_ctl_ff <= '0;
         e2_ctl_ff <= '0;
         e3_ctl_ff <= '0;
      end else if (advance) begin
         e1_ctl_ff <= s1_ctl;
         e2_ctl_ff <= e1_ctl_ff;
         e3_ctl_ff <= e2_ctl_ff;
      end
   end

   // Advance the datapath
   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         mag_ff  <= mag_in;
         neg_ff  <= neg_in;
         neg3_ff <= neg_ff;
         for (int a = 0; a < 2; a++) begin
            scaled_ff[a] <= SC_W'(mag_ff[a]) * SC_W'(RECIP_M);
         end
      end
   end

   assign ev_ctl = e3_ctl_ff;

   // A first step and a last step never share a word unless one step per curve
   a_first_last: assert property (@(posedge clock) disable iff (reset)
      (e3_ctl_ff.valid && e3_ctl_ff.first && e3_ctl_ff.last) |-> (STEPS == 0))
      else $error("first and last step collide");

   // The first step puts the whole weight on the start point
   a_first_start: assert property (@(posedge clock) disable iff (reset)
      (s1_ctl.valid && s1_ctl.first)
      |-> (s1_wgt[0] == WW'(DIV)) && (s1_wgt[1] == '0) && (s1_wgt[2] == '0))
      else $error("first step not weighted on the start point");

   // Control words stay put while the pipeline is stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(e3_ctl_ff))
      else $error("control moved during stall");

endmodule

[hdl/quadratic_bezier_flattener_top.sv]
// ----------------------------------------------------------------------------
// quadratic_bezier_flattener_top
// Flattens quadratic Bezier curves into STEPS+1 line segments each.
// ----------------------------------------------------------------------------
// Each curve transfer on req_ch yields STEPS+1 segment transfers on rsp_ch,
// one per cycle while rsp_ch is ready. The step sequencer issues one
// evaluation per cycle while the pipeline advances and takes the next curve
// in the same cycle as the final step of the previous one, so curves stream
// with no gap. Each segment passes through the sequencer, product, sum,
// reciprocal multiply and output register in that order. A stall on rsp_ch
// freezes the whole pipeline.
module quadratic_bezier_flattener_top #(
   parameter int STEPS = bzf_pkg::STEPS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   bzf_req_if.sink  req_ch,
   bzf_rsp_if.source rsp_ch
);
   import bzf_pkg::*;

   localparam int WW = weight_width(STEPS);

   logic                 advance;
   ctl_type              s1_ctl;
   logic [2:0][WW-1:0]   s1_wgt;
   coord_type [1:0][2:0] s1_pts;
   ctl_type              ev_ctl;
   coord_type [1:0]      ev_cur;

   logic                 rsp_valid_ff;
   logic                 rsp_last_ff;
   coord_type            cur_x_ff;
   coord_type            cur_y_ff;
   coord_type            prev_x_ff;
   coord_type            prev_y_ff;

   // Move the pipeline when the output register is free or being drained
   assign advance = !rsp_valid_ff || rsp_ch.ready;

   bzf_seq #(.STEPS(STEPS)) u_seq (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req_ch  (req_ch),
      .s1_ctl  (s1_ctl),
      .s1_wgt  (s1_wgt),
      .s1_pts  (s1_pts)
   );

   bzf_eval #(.STEPS(STEPS)) u_eval (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .s1_ctl  (s1_ctl),
      .s1_wgt  (s1_wgt),
      .s1_pts  (s1_pts),
      .ev_ctl  (ev_ctl),
      .ev_cur  (ev_cur)
   );

   // Output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= ev_ctl.valid;
      end
   end

   // Load a segment; the previous point is the last emitted current point,
   // or the point itself on the first step since it equals the start point
   always_ff @(posedge clock) begin
      if (advance && ev_ctl.valid) begin
         cur_x_ff    <= ev_cur[0];
         cur_y_ff    <= ev_cur[1];
         prev_x_ff   <= ev_ctl.first ? ev_cur[0] : cur_x_ff;
         prev_y_ff   <= ev_ctl.first ? ev_cur[1] : cur_y_ff;
         rsp_last_ff <= ev_ctl.last;
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.cur_x  = cur_x_ff;
   assign rsp_ch.cur_y  = cur_y_ff;
   assign rsp_ch.prev_x = prev_x_ff;
   assign rsp_ch.prev_y = prev_y_ff;
   assign rsp_ch.last   = rsp_last_ff;

   // A segment held in the output register is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |=> $stable(cur_x_ff) && $stable(prev_x_ff))
      else $error("pending segment overwritten");

   // Consecutive segments chain: the new previous point is the old current one
   a_chain: assert property (@(posedge clock) disable iff (reset)
      (advance && ev_ctl.valid && !ev_ctl.first && rsp_valid_ff)
      |=> (prev_x_ff == $past(cur_x_ff)) && (prev_y_ff == $past(cur_y_ff)))
      else $error("segment chain broken");

   // The sequencer only takes a curve when the pipeline moves
   a_accept_moves: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |-> advance)
      else $error("curve accepted during stall");

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks quadratic_bezier_flattener_top. Curves go in on the request channel.
// An in-bench flattener works out the STEPS+1 segments that each curve should
// give, and every segment on the response channel is compared with the
// oldest one still pending. A table of directed curves comes first, then
// random curves. Both channels idle and stall at random, and the response
// side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
   import bzf_pkg::*;

   localparam int STEPS       = STEPS_DEF;
   localparam int RAND_CURVES = 92;
   localparam int CALM_CURVES = 15;
   localparam int HOLD_AT     = 40 * (STEPS + 1);
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 20;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type ctrl_x;
      coord_type ctrl_y;
      coord_type finish_x;
      coord_type finish_y;
   } curve_type;

   typedef struct packed {
      coord_type cur_x;
      coord_type cur_y;
      coord_type prev_x;
      coord_type prev_y;
      logic      last;
   } segment_type;

   // A directed curve; when fixed is set every segment is the point (fix_x, fix_y)
   typedef struct packed {
      curve_type crv;
      logic      fixed;
      coord_type fix_x;
      coord_type fix_y;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 18;

   directed_row_type directed_curves [DIRECTED_ROWS] = '{
      // all points equal: zero, both extremes, mixed extremes, sign bits
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, 16'sd0, 16'sd0},
      '{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767},
        1'b1, 16'sd32767, 16'sd32767},
      '{'{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000},
        1'b1, 16'h8000, 16'h8000},
      '{'{16'sd32767, 16'h8000, 16'sd32767, 16'h8000, 16'sd32767, 16'h8000},
        1'b1, 16'sd32767, 16'h8000},
      '{'{16'hFFFF, 16'sd1, 16'hFFFF, 16'sd1, 16'hFFFF, 16'sd1}, 1'b1, 16'hFFFF, 16'sd1},
      // control point at the opposite corner of the range
      '{'{16'h8000, 16'h8000, 16'sd32767, 16'sd32767, 16'h8000, 16'h8000}, 1'b0, '0, '0},
      '{'{16'sd32767, 16'sd32767, 16'h8000, 16'h8000, 16'sd32767, 16'sd32767}, 1'b0, '0, '0},
      // full-range diagonal and reversed diagonal
      '{'{16'h8000, 16'h8000, 16'sd0, 16'sd0, 16'sd32767, 16'sd32767}, 1'b0, '0, '0},
      '{'{16'sd32767, 16'sd32767, 16'h8000, 16'h8000, 16'h8000, 16'h8000}, 1'b0, '0, '0},
      // alternating bit patterns
      '{'{16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA}, 1'b0, '0, '0},
      // truncation toward zero on negative and positive sums
      '{'{16'hFFFF, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0, '0},
      '{'{16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0, '0},
      '{'{-16'sd50, 16'sd50, -16'sd49, 16'sd49, -16'sd1, 16'sd1}, 1'b0, '0, '0},
      // only the control point off the origin, control point at it, only the end point off it, extremes, small points
      '{'{16'sd0, 16'sd0, 16'h8000, 16'sd32767, 16'sd0, 16'sd0}, 1'b0, '0, '0},
      '{'{16'sd100, -16'sd100, 16'sd0, 16'sd0, -16'sd100, 16'sd100}, 1'b0, '0, '0},
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd2499, -16'sd2499}, 1'b0, '0, '0},
      '{'{16'h8000, 16'sd32767, 16'sd32767, 16'h8000, 16'h8000, 16'sd32767}, 1'b0, '0, '0},
      '{'{16'sd1, -16'sd1, 16'sd2, -16'sd2, 16'sd3, -16'sd3}, 1'b0, '0, '0}
   };

   logic clock;
   logic reset;

   bzf_req_if req_bus ();
   bzf_rsp_if rsp_bus ();

   segment_type pending_segments [$];
   int          mismatch_count = 0;
   int          segments_seen  = 0;
   bit          calm           = 1'b0;

   quadratic_bezier_flattener_top #(
      .STEPS (STEPS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // Clock and reset
   initial begin
      clock = 1'b0;
   end

   always #1 clock = ~clock;

   initial begin
      reset <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // Point on the curve at t = k/STEPS, quotient truncated toward zero
   function automatic coord_type bezier_point(coord_type p0, coord_type p1, coord_type p2,
                                              int k);
      longint r;
      longint num;
      r   = STEPS - k;
      num = r * r * longint'(p0) + 2 * longint'(k) * r * longint'(p1)
            + longint'(k) * k * longint'(p2);
      return coord_type'(num / (STEPS * STEPS));
   endfunction

   // Queue the segments that one curve flattens into
   function automatic void flatten_curve(curve_type crv);
      segment_type seg;
      coord_type   px;
      coord_type   py;
      px = crv.start_x;
      py = crv.start_y;
      for (int k = 0; k <= STEPS; k++) begin
         seg.cur_x  = bezier_point(crv.start_x, crv.ctrl_x, crv.finish_x, k);
         seg.cur_y  = bezier_point(crv.start_y, crv.ctrl_y, crv.finish_y, k);
         seg.prev_x = px;
         seg.prev_y = py;
         seg.last   = (k == STEPS);
         pending_segments.push_back(seg);
         px = seg.cur_x;
         py = seg.cur_y;
      end
   endfunction

   // Queue STEPS+1 copies of one fixed point
   function automatic void queue_fixed_point(coord_type fx, coord_type fy);
      for (int k = 0; k <= STEPS; k++)
         pending_segments.push_back('{fx, fy, fx, fy, (k == STEPS)});
   endfunction

   function automatic coord_type random_coord(int mode);
      coord_type val;
      case (mode)
         2: val = coord_type'(int'($urandom_range(0, 400)) - 200);
         3: begin
            case ($urandom_range(0, 5))
               0: val = 16'h8000;
               1: val = 16'sd32767;
               2: val = 16'sd0;
               3: val = 16'hFFFF;
               4: val = 16'sd1;
               default: val = 16'($urandom);
            endcase
         end
         default: val = 16'($urandom);
      endcase
      return val;
   endfunction

   function automatic curve_type random_curve();
      curve_type crv;
      int        mode;
      mode         = $urandom_range(0, 3);
      crv.start_x  = random_coord(mode);
      crv.start_y  = random_coord(mode);
      crv.ctrl_x   = random_coord(mode);
      crv.ctrl_y   = random_coord(mode);
      crv.finish_x = random_coord(mode);
      crv.finish_y = random_coord(mode);
      return crv;
   endfunction

   // Offer one curve and hold it until the transfer
   task automatic send_curve(curve_type crv, logic fixed, coord_type fx, coord_type fy);
      req_bus.valid    <= 1'b1;
      req_bus.start_x  <= crv.start_x;
      req_bus.start_y  <= crv.start_y;
      req_bus.ctrl_x   <= crv.ctrl_x;
      req_bus.ctrl_y   <= crv.ctrl_y;
      req_bus.finish_x <= crv.finish_x;
      req_bus.finish_y <= crv.finish_y;
      do @(posedge clock); while (!req_bus.ready);
      if (fixed)
         queue_fixed_point(fx, fy);
      else
         flatten_curve(crv);
   endtask

   // Drop valid for a random burst now and then
   task automatic maybe_idle_sender();
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_segments();
      req_bus.valid <= 1'b0;
      while (pending_segments.size() != 0) @(posedge clock);
   endtask

   // Curve sender: directed table, a full drain, then random curves
   initial begin : curve_sender
      req_bus.valid    <= 1'b0;
      req_bus.start_x  <= '0;
      req_bus.start_y  <= '0;
      req_bus.ctrl_x   <= '0;
      req_bus.ctrl_y   <= '0;
      req_bus.finish_x <= '0;
      req_bus.finish_y <= '0;
      do @(posedge clock); while (reset);

      foreach (directed_curves[i]) begin
         send_curve(directed_curves[i].crv, directed_curves[i].fixed,
                    directed_curves[i].fix_x, directed_curves[i].fix_y);
         maybe_idle_sender();
      end

      // pause until every segment of the directed part is out
      drain_segments();

      for (int n = 0; n < RAND_CURVES; n++) begin
         if (n == RAND_CURVES - CALM_CURVES)
            calm = 1'b1;
         send_curve(random_curve(), 1'b0, '0, '0);
         maybe_idle_sender();
      end

      drain_segments();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("quadratic_bezier_flattener_top test passed");
      else
         $display("quadratic_bezier_flattener_top test failed");
      $finish;
   end

   // Segment receiver: random stall bursts and one long hold-off
   initial begin : segment_receiver
      int  stall_left;
      int  hold_left;
      bit  held;
      stall_left = 0;
      hold_left  = 0;
      held       = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held && segments_seen >= HOLD_AT) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 19) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Compare each segment transfer with the oldest pending segment
   always @(posedge clock) begin : segment_checker
      segment_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         segments_seen++;
         if (pending_segments.size() == 0) begin
            $display("%0t: segment expected none actual (%0d,%0d)-(%0d,%0d) last %0d",
                     $time, rsp_bus.cur_x, rsp_bus.cur_y, rsp_bus.prev_x,
                     rsp_bus.prev_y, rsp_bus.last);
            mismatch_count++;
         end else begin
            want = pending_segments.pop_front();
            check_field("cur_x", want.cur_x, rsp_bus.cur_x);
            check_field("cur_y", want.cur_y, rsp_bus.cur_y);
            check_field("prev_x", want.prev_x, rsp_bus.prev_x);
            check_field("prev_y", want.prev_y, rsp_bus.prev_y);
            check_field("last", want.last, rsp_bus.last);
         end
      end
   end

   // Timeout
   initial begin
      #1000000;
      $display("quadratic_bezier_flattener_top test failed");
      $finish;
   end

endmodule

[sim.f]
hdl/bzf_pkg.sv
hdl/bzf_req_if.sv
hdl/bzf_rsp_if.sv
hdl/bzf_seq.sv
hdl/bzf_eval.sv
hdl/quadratic_bezier_flattener_top.sv
test/testbench.sv
